>>> rtl/core/amtc_pkg.sv
// Shared types and constants of the ALOHA MAC transmit controller.
// No dependencies; used by the channel interfaces and every RTL module.
`default_nettype none

package amtc_pkg;

  // MAC mode codes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WAIT  = 3'd1,
    MODE_TRY   = 3'd2,
    MODE_SLEEP = 3'd3,
    MODE_DOWN  = 3'd4
  } mode_t;

  // Event kinds on the input channel
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_OUTCOME = 2'd2,
    KIND_REQUEST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RADIO_RX    = 2'd0,
    RADIO_SLEEP = 2'd1,
    RADIO_DOWN  = 2'd2
  } radio_t;

  typedef enum logic [1:0] {
    OUTC_NONE    = 2'd0,
    OUTC_SENT    = 2'd1,
    OUTC_DROPPED = 2'd2
  } outcome_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOAD_FACTOR = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRY   = 2'd1;
  localparam logic [1:0] CFG_LFSR_SEED   = 2'd2;

  // Request bit positions
  localparam int REQ_SLEEP = 0;
  localparam int REQ_WAKE  = 1;
  localparam int REQ_SHUT  = 2;
  localparam int REQ_START = 3;

  localparam logic [7:0]  LOAD_RESET    = 8'd5;
  localparam logic [3:0]  RETRY_RESET   = 4'd3;
  localparam logic [15:0] SEED_DEFAULT  = 16'd78;

  localparam int BACKOFF_W = 11;
  localparam int RETRY_W   = 5;

  // One input beat
  typedef struct packed {
    logic [1:0] kind;
    logic       attempt_ok;
    logic [3:0] request_bits;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [2:0]         mac_mode;
    logic [1:0]         radio_mode;
    logic               start_attempt;
    logic               frame_accepted;
    logic [1:0]         frame_outcome;
    logic [RETRY_W-1:0] retries_used;
    logic               frame_waiting;
  } result_t;

  // Configuration seen by the step logic
  typedef struct packed {
    logic [7:0]  load_factor;
    logic [3:0]  max_retry;
    logic        seed_we;
    logic [15:0] seed_val;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/amtc_ifs.sv
// Valid/ready channel interfaces of the transmit controller: input events,
// results and configuration writes. Depends on amtc_pkg.
`default_nettype none

interface amtc_in_if import amtc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       attempt_ok;
  logic [3:0] request_bits;

  modport source (output valid, kind, attempt_ok, request_bits, input ready);
  modport sink   (input valid, kind, attempt_ok, request_bits, output ready);
endinterface

interface amtc_out_if import amtc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         mac_mode;
  logic [1:0]         radio_mode;
  logic               start_attempt;
  logic               frame_accepted;
  logic [1:0]         frame_outcome;
  logic [RETRY_W-1:0] retries_used;
  logic               frame_waiting;

  modport source (output valid, mac_mode, radio_mode, start_attempt, frame_accepted,
                  frame_outcome, retries_used, frame_waiting, input ready);
  modport sink   (input valid, mac_mode, radio_mode, start_attempt, frame_accepted,
                  frame_outcome, retries_used, frame_waiting, output ready);
endinterface

interface amtc_cfg_if import amtc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/amtc_cfg_regs.sv
// Configuration register file: load factor, retry limit, seed write strobe.
// Depends on amtc_pkg.
`default_nettype none

module amtc_cfg_regs import amtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_valid,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data,
  output cfg_t             cfg
);

  logic [7:0] load_factor;
  logic [3:0] max_retry;
  logic       wr_load;
  logic       wr_retry;
  logic       wr_seed;

  // index decode
  always_comb begin
    wr_load  = wr_valid && (wr_index == CFG_LOAD_FACTOR);
    wr_retry = wr_valid && (wr_index == CFG_MAX_RETRY);
    wr_seed  = wr_valid && (wr_index == CFG_LFSR_SEED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_factor <= LOAD_RESET;
      max_retry   <= RETRY_RESET;
    end else begin
      if (wr_load)  load_factor <= wr_data[7:0];
      if (wr_retry) max_retry   <= wr_data[3:0];
    end
  end

  // seed goes straight to the LFSR; zero maps to the default seed
  always_comb begin
    cfg.load_factor = load_factor;
    cfg.max_retry   = max_retry;
    cfg.seed_we     = wr_seed;
    cfg.seed_val    = (wr_data != 16'd0) ? wr_data : SEED_DEFAULT;
  end

endmodule

`default_nettype wire

>>> rtl/core/amtc_step.sv
// MAC state registers and the combinational event update (mode machine,
// backoff draw, retry logic, request handling). Depends on amtc_pkg.
`default_nettype none

module amtc_step import amtc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  item_t     item,
  input  cfg_t      cfg,
  output result_t   res
);

  mode_t                mode_reg, mode_next;
  logic                 frame_pending, frame_pending_next;
  logic [RETRY_W-1:0]   retry_count, retry_count_next;
  logic [BACKOFF_W-1:0] backoff_left, backoff_left_next;
  logic [15:0]          random_reg, random_reg_next;
  logic [3:0]           pending_requests, pending_requests_next;

  logic [15:0]          lfsr_adv;
  logic [23:0]          prod;
  logic [BACKOFF_W-1:0] draw;
  logic                 start;
  logic                 accepted;
  outcome_t             outcome;
  radio_t               radio;

  // LFSR advance and scaled backoff draw: (lfsr * load * 8) >> 16
  always_comb begin
    lfsr_adv = {random_reg[0] ^ random_reg[2] ^ random_reg[3] ^ random_reg[5],
                random_reg[15:1]};
    prod     = 24'(lfsr_adv) * 24'(cfg.load_factor);
    draw     = prod[23:13];
  end

  // next state
  always_comb begin
    mode_next             = mode_reg;
    frame_pending_next    = frame_pending;
    retry_count_next      = retry_count;
    backoff_left_next     = backoff_left;
    random_reg_next       = random_reg;
    pending_requests_next = pending_requests;
    start                 = 1'b0;
    accepted              = 1'b0;
    outcome               = OUTC_NONE;

    // take in the event first
    if (item.kind == KIND_FRAME) begin
      if (!frame_pending) begin
        frame_pending_next = 1'b1;
        accepted           = 1'b1;
      end
    end else if (item.kind == KIND_REQUEST) begin
      pending_requests_next = pending_requests | item.request_bits;
    end

    case (mode_reg)
      MODE_IDLE: begin
        if (frame_pending_next) begin
          backoff_left_next = draw;
          random_reg_next   = lfsr_adv;
          mode_next         = MODE_WAIT;
        end else if (pending_requests_next[REQ_SLEEP]) begin
          pending_requests_next[REQ_SLEEP] = 1'b0;
          mode_next                        = MODE_SLEEP;
        end
      end
      MODE_WAIT: begin
        if (item.kind == KIND_TICK && backoff_left != '0)
          backoff_left_next = backoff_left - BACKOFF_W'(1);
        if (backoff_left_next == '0) begin
          mode_next = MODE_TRY;
          start     = 1'b1;
        end
      end
      MODE_TRY: begin
        if (item.kind == KIND_OUTCOME) begin
          if (item.attempt_ok) begin
            frame_pending_next = 1'b0;
            retry_count_next   = '0;
            outcome            = OUTC_SENT;
            mode_next          = MODE_IDLE;
          end else if (retry_count > {1'b0, cfg.max_retry}) begin
            frame_pending_next = 1'b0;
            retry_count_next   = '0;
            outcome            = OUTC_DROPPED;
            mode_next          = MODE_IDLE;
          end else begin
            backoff_left_next = draw;
            random_reg_next   = lfsr_adv;
            retry_count_next  = retry_count + RETRY_W'(1);
            mode_next         = MODE_WAIT;
          end
        end
      end
      MODE_SLEEP: begin
        if (pending_requests_next[REQ_WAKE]) begin
          pending_requests_next[REQ_WAKE] = 1'b0;
          mode_next                       = MODE_IDLE;
        end
      end
      MODE_DOWN: begin
      end
      default: mode_next = MODE_IDLE;
    endcase

    // shutdown applies in any mode
    if (pending_requests_next[REQ_SHUT]) begin
      frame_pending_next              = 1'b0;
      backoff_left_next               = '0;
      retry_count_next                = '0;
      pending_requests_next[REQ_SHUT] = 1'b0;
      mode_next                       = MODE_DOWN;
    end
    if (pending_requests_next[REQ_START] && mode_next == MODE_DOWN) begin
      pending_requests_next[REQ_START] = 1'b0;
      mode_next                        = MODE_IDLE;
    end
  end

  // result of this step
  always_comb begin
    case (mode_next)
      MODE_SLEEP: radio = RADIO_SLEEP;
      MODE_DOWN:  radio = RADIO_DOWN;
      default:    radio = RADIO_RX;
    endcase
    res.mac_mode       = mode_next;
    res.radio_mode     = radio;
    res.start_attempt  = start;
    res.frame_accepted = accepted;
    res.frame_outcome  = outcome;
    res.retries_used   = retry_count_next;
    res.frame_waiting  = frame_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_IDLE;
      frame_pending    <= 1'b0;
      retry_count      <= '0;
      backoff_left     <= '0;
      random_reg       <= SEED_DEFAULT;
      pending_requests <= '0;
    end else begin
      if (go) begin
        mode_reg         <= mode_next;
        frame_pending    <= frame_pending_next;
        retry_count      <= retry_count_next;
        backoff_left     <= backoff_left_next;
        pending_requests <= pending_requests_next;
      end
      if (cfg.seed_we)
        random_reg <= cfg.seed_val;
      else if (go)
        random_reg <= random_reg_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aloha_mac_tx_controller_top.sv
// Top level of the ALOHA MAC transmit controller: input register, step
// logic, result register. Depends on amtc_pkg, amtc_ifs, amtc_cfg_regs, amtc_step.
//
// Usage:
//   in_ch  : one event per beat (tick, frame queued, attempt outcome, requests).
//   out_ch : exactly one result beat per event, in order.
//   cfg    : register writes (0 load factor, 1 max retry, 2 LFSR seed); always
//            ready; write only while no event is in flight.
// Path: an event accepted on in_ch passes the input register, then the result register.
// Throughput: one event per cycle while out_ch does not stall; the update of the MAC
//   state registers is a loop through the LFSR step and one 16x8 backoff multiply.
// Reset (rst, synchronous): idle mode, no frame, retry count and backoff
//   zero, LFSR at 78, registers at defaults; both pipeline stages empty.
// Stall: while out_ch is not ready the result holds; one more event is kept
//   in the input register, after which in_ch.ready drops.
`default_nettype none

module aloha_mac_tx_controller_top import amtc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  amtc_in_if.sink   in_ch,
  amtc_out_if.source out_ch,
  amtc_cfg_if.sink  cfg
);

  logic    ireg_valid;
  item_t   ireg;
  item_t   item_in;
  logic    step_go;
  logic    ovalid;
  result_t ores;
  result_t step_res;
  cfg_t    cfg_bus;

  // handshake: step runs when the result register is free or drains
  always_comb begin
    step_go     = ireg_valid && (!ovalid || out_ch.ready);
    in_ch.ready = !ireg_valid || step_go;
    cfg.ready   = 1'b1;
    item_in.kind         = in_ch.kind;
    item_in.attempt_ok   = in_ch.attempt_ok;
    item_in.request_bits = in_ch.request_bits;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ch.ready) begin
      ireg_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) ireg <= item_in;
  end

  amtc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_bus)
  );

  amtc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .go   (step_go),
    .item (ireg),
    .cfg  (cfg_bus),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (step_go) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) ores <= step_res;
  end

  always_comb begin
    out_ch.valid          = ovalid;
    out_ch.mac_mode       = ores.mac_mode;
    out_ch.radio_mode     = ores.radio_mode;
    out_ch.start_attempt  = ores.start_attempt;
    out_ch.frame_accepted = ores.frame_accepted;
    out_ch.frame_outcome  = ores.frame_outcome;
    out_ch.retries_used   = ores.retries_used;
    out_ch.frame_waiting  = ores.frame_waiting;
  end

`ifndef SYNTH
  // a step always leaves a result behind
  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step_go |=> out_ch.valid)
    else $error("step result not presented");

  // input backpressure only when both stages are full and the sink stalls
  a_ready_low_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (ireg_valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled without cause");

  // a finished frame leaves no frame and no retries behind
  a_outcome_clears: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_outcome != OUTC_NONE)
      |-> (!out_ch.frame_waiting && out_ch.retries_used == '0))
    else $error("frame outcome left state behind");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_aloha_mac_tx_controller_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ALOHA MAC transmit controller top level.
// Depends on amtc_pkg, amtc_ifs and the RTL under rtl/core.

module tb_aloha_mac_tx_controller_top import amtc_pkg::*;;

  // index with no register behind it; writes there must change nothing
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Tracks the MAC state, predicts one status beat per event, checks results
  class mac_tx_scoreboard;
    logic [7:0]         load_factor;
    logic [3:0]         max_retry;
    mode_t              mode;
    logic               frame_pending;
    logic [RETRY_W-1:0] retry_count;
    logic [BACKOFF_W-1:0] backoff_left;
    logic [15:0]        lfsr;
    logic [3:0]         requests;
    result_t            awaited_status[$];
    int unsigned        n_events, n_results, n_errors, n_writes;
    int unsigned        n_starts, n_sent, n_dropped, n_refused;

    function new();
      load_factor   = LOAD_RESET;
      max_retry     = RETRY_RESET;
      mode          = MODE_IDLE;
      frame_pending = 1'b0;
      retry_count   = '0;
      backoff_left  = '0;
      lfsr          = SEED_DEFAULT;
      requests      = 4'b0;
    endfunction

    function void write_register(logic [1:0] index, logic [15:0] data);
      n_writes++;
      case (index)
        CFG_LOAD_FACTOR: load_factor = data[7:0];
        CFG_MAX_RETRY:   max_retry = data[3:0];
        CFG_LFSR_SEED:   lfsr = (data != 16'd0) ? data : SEED_DEFAULT;
        default: ;
      endcase
    endfunction

    // One right-shift LFSR step, then scale into a window of load*8 ticks
    function logic [BACKOFF_W-1:0] draw_backoff();
      logic        fb;
      logic [31:0] prod;
      fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
      lfsr = {fb, lfsr[15:1]};
      prod = {16'd0, lfsr} * {24'd0, load_factor} * 32'd8;
      return prod[26:16];
    endfunction

    // Accepted event: advance the MAC and queue the status it must produce
    function void note_event(item_t ev);
      result_t want;
      logic    start, accepted;
      logic [1:0] outcome;
      start    = 1'b0;
      accepted = 1'b0;
      outcome  = OUTC_NONE;
      n_events++;

      if (ev.kind == KIND_FRAME) begin
        if (!frame_pending) begin
          frame_pending = 1'b1;
          accepted = 1'b1;
        end else begin
          n_refused++;
        end
      end else if (ev.kind == KIND_REQUEST) begin
        requests = requests | ev.request_bits;
      end

      case (mode)
        MODE_IDLE: begin
          if (frame_pending) begin
            backoff_left = draw_backoff();
            mode = MODE_WAIT;
          end else if (requests[REQ_SLEEP]) begin
            requests[REQ_SLEEP] = 1'b0;
            mode = MODE_SLEEP;
          end
        end
        MODE_WAIT: begin
          if (ev.kind == KIND_TICK && backoff_left != '0) backoff_left = backoff_left - 1'b1;
          if (backoff_left == '0) begin
            mode = MODE_TRY;
            start = 1'b1;
          end
        end
        MODE_TRY: begin
          if (ev.kind == KIND_OUTCOME) begin
            if (ev.attempt_ok) begin
              frame_pending = 1'b0;
              retry_count = '0;
              outcome = OUTC_SENT;
              mode = MODE_IDLE;
            end else if (retry_count > {1'b0, max_retry}) begin
              frame_pending = 1'b0;
              retry_count = '0;
              outcome = OUTC_DROPPED;
              mode = MODE_IDLE;
            end else begin
              backoff_left = draw_backoff();
              retry_count = retry_count + 1'b1;
              mode = MODE_WAIT;
            end
          end
        end
        MODE_SLEEP: begin
          if (requests[REQ_WAKE]) begin
            requests[REQ_WAKE] = 1'b0;
            mode = MODE_IDLE;
          end
        end
        MODE_DOWN: ;
        default: mode = MODE_IDLE;
      endcase

      // shutdown wins in any mode; startup then leaves powerdown
      if (requests[REQ_SHUT]) begin
        frame_pending = 1'b0;
        backoff_left = '0;
        retry_count = '0;
        requests[REQ_SHUT] = 1'b0;
        mode = MODE_DOWN;
      end
      if (requests[REQ_START] && mode == MODE_DOWN) begin
        requests[REQ_START] = 1'b0;
        mode = MODE_IDLE;
      end

      if (start) n_starts++;
      if (outcome == OUTC_SENT) n_sent++;
      if (outcome == OUTC_DROPPED) n_dropped++;

      want.mac_mode       = mode;
      want.radio_mode     = (mode == MODE_SLEEP) ? RADIO_SLEEP :
                            (mode == MODE_DOWN) ? RADIO_DOWN : RADIO_RX;
      want.start_attempt  = start;
      want.frame_accepted = accepted;
      want.frame_outcome  = outcome;
      want.retries_used   = retry_count;
      want.frame_waiting  = frame_pending;
      awaited_status.push_back(want);
    endfunction

    function int pending();
      return awaited_status.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      n_errors++;
    endtask

    task check_field(string field, logic [4:0] got, logic [4:0] want);
      if (got !== want)
        report_mismatch($sformatf("status beat %0d: %s is %0d, expected %0d",
                                  n_results, field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_status.size() == 0) begin
        report_mismatch("status beat with no event outstanding");
        return;
      end
      want = awaited_status.pop_front();
      check_field("mac_mode",       5'(got.mac_mode),       5'(want.mac_mode));
      check_field("radio_mode",     5'(got.radio_mode),     5'(want.radio_mode));
      check_field("start_attempt",  5'(got.start_attempt),  5'(want.start_attempt));
      check_field("frame_accepted", 5'(got.frame_accepted), 5'(want.frame_accepted));
      check_field("frame_outcome",  5'(got.frame_outcome),  5'(want.frame_outcome));
      check_field("retries_used",   5'(got.retries_used),   5'(want.retries_used));
      check_field("frame_waiting",  5'(got.frame_waiting),  5'(want.frame_waiting));
      n_results++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   no_gaps = 1'b0;

  mac_tx_scoreboard sb = new();

  amtc_in_if  in_ch ();
  amtc_out_if out_ch ();
  amtc_cfg_if cfg ();

  aloha_mac_tx_controller_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #10 clk = ~clk;

  function automatic item_t make_event(kind_t kind, logic ok, logic [3:0] req);
    item_t ev;
    ev.kind = kind;
    ev.attempt_ok = ok;
    ev.request_bits = req;
    return ev;
  endfunction

  // Mostly the event the current mode is waiting for, with random don't-care bits;
  // the rest is noise
  function automatic item_t pick_event();
    item_t ev;
    int    roll;
    ev.kind = KIND_TICK;
    ev.attempt_ok = 1'($urandom_range(1));
    ev.request_bits = 4'($urandom_range(15));
    if ($urandom_range(99) < 12) begin
      ev.kind = 2'($urandom_range(3));
      return ev;
    end
    roll = $urandom_range(99);
    case (sb.mode)
      MODE_IDLE: begin
        if (roll < 70) ev.kind = KIND_FRAME;
        else if (roll < 85) ev.kind = KIND_TICK;
        else begin
          ev.kind = KIND_REQUEST;
          if (roll < 95) ev.request_bits = 4'b1 << REQ_SLEEP;
        end
      end
      MODE_WAIT: begin
        if (roll < 90) ev.kind = KIND_TICK;
        else if (roll < 94) ev.kind = KIND_FRAME;
        else if (roll < 97) ev.kind = KIND_OUTCOME;
        else ev.kind = KIND_REQUEST;
      end
      MODE_TRY: begin
        if (roll < 80) begin
          ev.kind = KIND_OUTCOME;
          ev.attempt_ok = ($urandom_range(99) < 40);
        end else if (roll < 92) ev.kind = KIND_TICK;
        else if (roll < 96) ev.kind = KIND_FRAME;
        else ev.kind = KIND_REQUEST;
      end
      MODE_SLEEP: begin
        if (roll < 50) begin
          ev.kind = KIND_REQUEST;
          ev.request_bits = 4'b1 << REQ_WAKE;
        end else if (roll < 80) ev.kind = KIND_TICK;
        else ev.kind = KIND_FRAME;
      end
      default: begin
        if (roll < 45) begin
          ev.kind = KIND_REQUEST;
          ev.request_bits = 4'b1 << REQ_START;
        end else if (roll < 75) ev.kind = KIND_TICK;
        else ev.kind = KIND_FRAME;
      end
    endcase
    return ev;
  endfunction

  // Drive one event beat, with random idle cycles ahead of it unless no_gaps is set
  task automatic send_event(item_t ev);
    if (!no_gaps) begin
      while ($urandom_range(99) < 10) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= ev.kind;
    in_ch.attempt_ok   <= ev.attempt_ok;
    in_ch.request_bits <= ev.request_bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_event(ev);
  endtask

  // Stop sending and wait until every status beat is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all registers, upper data bits random where the register is narrow
  task automatic program_registers(logic [7:0] load, logic [3:0] retries, logic [15:0] seed);
    logic [1:0]  order [4];
    logic [15:0] word [4];
    order[0] = CFG_LOAD_FACTOR;
    order[1] = CFG_MAX_RETRY;
    order[2] = CFG_LFSR_SEED;
    order[3] = CFG_UNUSED;
    word[0] = {8'($urandom_range(255)), load};
    word[1] = {12'($urandom_range(4095)), retries};
    word[2] = seed;
    word[3] = 16'($urandom_range(65535));
    for (int i = 0; i < 4; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= order[i];
      cfg.data  <= word[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      sb.write_register(order[i], word[i]);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] load, logic [3:0] retries, logic [15:0] seed,
                           int count);
    program_registers(load, retries, seed);
    repeat (count) send_event(pick_event());
    drain();
  endtask

  // Result side: random back-pressure unless no_gaps is set, check every accepted beat
  initial begin : status_sink
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.mac_mode       = out_ch.mac_mode;
        got.radio_mode     = out_ch.radio_mode;
        got.start_attempt  = out_ch.start_attempt;
        got.frame_accepted = out_ch.frame_accepted;
        got.frame_outcome  = out_ch.frame_outcome;
        got.retries_used   = out_ch.retries_used;
        got.frame_waiting  = out_ch.frame_waiting;
        sb.check_result(got);
      end
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 10);
    end
  end

  // Stimulus
  initial begin : stimulus
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_TICK;
    in_ch.attempt_ok   <= 1'b0;
    in_ch.request_bits <= 4'b0;
    cfg.valid          <= 1'b0;
    cfg.index          <= CFG_LOAD_FACTOR;
    cfg.data           <= 16'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: stray outcome, busy buffer, every mode and request
    send_event(make_event(KIND_OUTCOME, 1'b1, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b0000));
    send_event(make_event(KIND_FRAME,   1'b0, 4'b1111));
    send_event(make_event(KIND_FRAME,   1'b1, 4'b0000));
    send_event(make_event(KIND_TICK,    1'b1, 4'b1111));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_OUTCOME, 1'b0, 4'b0000));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_SHUT));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_OUTCOME, 1'b1, 4'b0000));
    send_event(make_event(KIND_FRAME,   1'b0, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_START));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_SHUT));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_START));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_SLEEP));
    // early startup stays pending while asleep
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_START));
    send_event(make_event(KIND_FRAME,   1'b0, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b0, 4'b1 << REQ_WAKE));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    send_event(make_event(KIND_REQUEST, 1'b1, 4'b1111));
    send_event(make_event(KIND_TICK,    1'b0, 4'b0000));
    drain();

    // random phases across the register extremes; zero seed falls back to default
    run_phase(8'd0,   4'd0,  16'hFFFF, 200);
    run_phase(8'd1,   4'd15, 16'h0000, 200);
    no_gaps = 1'b1;
    run_phase(8'd3,   4'd2,  16'($urandom_range(65535, 1)), 250);
    no_gaps = 1'b0;
    run_phase(8'd255, 4'd1,  16'h0001, 120);
    run_phase(8'($urandom_range(8)), 4'($urandom_range(15)),
              16'($urandom_range(65535)), 200);
    run_phase(8'd2,   4'd0,  16'hACE1, 180);

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d status beats never arrived", sb.pending()));
    $display("Covered %0d events and %0d status beats over %0d register writes.",
             sb.n_events, sb.n_results, sb.n_writes);
    $display("Attempts started %0d, frames sent %0d, dropped %0d, refused %0d.",
             sb.n_starts, sb.n_sent, sb.n_dropped, sb.n_refused);
    if (sb.n_errors == 0)
      $display("aloha_mac_tx_controller_top regression: pass");
    else
      $display("aloha_mac_tx_controller_top regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(4_000_000);
    $display("Timeout: run did not complete");
    $display("aloha_mac_tx_controller_top regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/amtc_pkg.sv
rtl/core/amtc_ifs.sv
rtl/core/amtc_cfg_regs.sv
rtl/core/amtc_step.sv
rtl/core/aloha_mac_tx_controller_top.sv
tb/sv/tb_aloha_mac_tx_controller_top.sv
